[rtl/core/order_crossover_engine_unit_assert.svh]
// assertion macros for the order crossover engine
`ifndef ORDER_CROSSOVER_ENGINE_UNIT_ASSERT_SVH
`define ORDER_CROSSOVER_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define OCX_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("order crossover check failed");

// next-cycle implication
`define OCX_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("order crossover check failed");

`endif

[rtl/core/ocx_pkg.sv]
// shared types and constants of the order crossover engine
`timescale 1ns / 1ps
package ocx_pkg;

  localparam int POS_W = 5;
  localparam int TOK_W = 16;
  localparam int LEN_W = 6;
  localparam logic [LEN_W-1:0] LEN_RESET = 6'd32;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_SWAP = 2'd1,
    CMD_RUN  = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [1:0]       command;
    logic [POS_W-1:0] position;
    logic [TOK_W-1:0] first_token;
    logic [TOK_W-1:0] second_token;
    logic [POS_W-1:0] cut_first;
    logic [POS_W-1:0] cut_second;
  } req_t;

  typedef struct packed {
    logic [POS_W-1:0] child_position;
    logic [TOK_W-1:0] child_token;
    logic             last;
    logic             error;
  } rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_LOAD, ST_SW_RD0, ST_SW_RD1, ST_SW_WR0, ST_SW_WR1,
    ST_CNT, ST_CNT_END, ST_BUDGET, ST_MK_RD, ST_MK_CHK, ST_MK_UPD,
    ST_SC_INIT, ST_SC_RD, ST_SC_CHK, ST_SC_DEC, ST_EM, ST_EM_END
  } state_e;

  typedef struct packed {
    logic capture;
    logic load_wr;
    logic swap_rd_a;
    logic swap_rd_b;
    logic swap_wr_a;
    logic swap_wr_b;
    logic cnt_rd;
    logic budget_set;
    logic mark_rd;
    logic mark_chk;
    logic mark_upd;
    logic scan_init;
    logic scan_rd;
    logic scan_chk;
    logic scan_dec;
    logic emit_rd;
  } ctrl_t;

  typedef struct packed {
    logic cnt_last;
    logic mark_last;
    logic fill_none;
    logic fill_done;
    logic fill_last;
    logic emit_last;
  } stat_t;

endpackage

[rtl/core/ocx_controller.sv]
// sequencing state machine of the order crossover engine
`timescale 1ns / 1ps
module ocx_controller import ocx_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] cmd_i,
  input  stat_t      stat_i,
  output ctrl_t      ctrl_o,
  output logic       busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          case (cmd_i)
            CMD_LOAD: state_d = ST_LOAD;
            CMD_SWAP: state_d = ST_SW_RD0;
            CMD_RUN:  state_d = ST_CNT;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_LOAD:    state_d = ST_IDLE;
      ST_SW_RD0:  state_d = ST_SW_RD1;
      ST_SW_RD1:  state_d = ST_SW_WR0;
      ST_SW_WR0:  state_d = ST_SW_WR1;
      ST_SW_WR1:  state_d = ST_IDLE;
      ST_CNT:     if (stat_i.cnt_last) state_d = ST_CNT_END;
      ST_CNT_END: state_d = ST_BUDGET;
      ST_BUDGET:  state_d = ST_MK_RD;
      ST_MK_RD:   state_d = ST_MK_CHK;
      ST_MK_CHK:  state_d = ST_MK_UPD;
      ST_MK_UPD:  state_d = stat_i.mark_last ? ST_SC_INIT : ST_MK_RD;
      ST_SC_INIT: state_d = stat_i.fill_none ? ST_EM : ST_SC_RD;
      ST_SC_RD:   state_d = ST_SC_CHK;
      ST_SC_CHK:  state_d = ST_SC_DEC;
      ST_SC_DEC: begin
        if (stat_i.fill_done && stat_i.fill_last) begin
          state_d = ST_EM;
        end else begin
          state_d = ST_SC_RD;
        end
      end
      ST_EM:      if (stat_i.emit_last) state_d = ST_EM_END;
      ST_EM_END:  state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    busy_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        ctrl_o.capture = start_i;
      end
      ST_LOAD:    ctrl_o.load_wr    = 1'b1;
      ST_SW_RD0:  ctrl_o.swap_rd_a  = 1'b1;
      ST_SW_RD1:  ctrl_o.swap_rd_b  = 1'b1;
      ST_SW_WR0:  ctrl_o.swap_wr_a  = 1'b1;
      ST_SW_WR1:  ctrl_o.swap_wr_b  = 1'b1;
      ST_CNT:     ctrl_o.cnt_rd     = 1'b1;
      ST_BUDGET:  ctrl_o.budget_set = 1'b1;
      ST_MK_RD:   ctrl_o.mark_rd    = 1'b1;
      ST_MK_CHK:  ctrl_o.mark_chk   = 1'b1;
      ST_MK_UPD:  ctrl_o.mark_upd   = 1'b1;
      ST_SC_INIT: ctrl_o.scan_init  = 1'b1;
      ST_SC_RD:   ctrl_o.scan_rd    = 1'b1;
      ST_SC_CHK:  ctrl_o.scan_chk   = 1'b1;
      ST_SC_DEC:  ctrl_o.scan_dec   = 1'b1;
      ST_EM:      ctrl_o.emit_rd    = 1'b1;
      default:    ctrl_o = '0;
    endcase
  end

endmodule

[rtl/core/ocx_datapath.sv]
// parent, child and used-token storage with the scan datapath
`timescale 1ns / 1ps
module ocx_datapath import ocx_pkg::*; #(
  parameter int MAX_GENES  = 32,
  parameter int TOKEN_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  req_t             req_i,
  input  logic [LEN_W-1:0] len_cfg_i,
  input  ctrl_t            ctrl_i,
  output stat_t            stat_o,
  output logic             result_valid_o,
  output rsp_t             rsp_o
);

  localparam int IW = (MAX_GENES > 1) ? $clog2(MAX_GENES) : 1;
  localparam int CW = $clog2(MAX_GENES + 1);
  localparam int TW = TOKEN_BITS;

  // captured request
  logic [CW-1:0] len_q;
  logic [IW-1:0] lo_q, hi_q, pos_q, posb_q;
  logic          pos_ok_q, swap_ok_q;
  logic [TW-1:0] tok_a_q, tok_b_q;

  logic [31:0]   len_raw, len32, lenm1, ca32, cb32;
  logic [CW-1:0] len_c;

  assign len_raw = 32'(len_cfg_i);

  always_comb begin
    if (len_raw < 32'd2) begin
      len_c = CW'(2);
    end else if (len_raw > 32'(MAX_GENES)) begin
      len_c = CW'(MAX_GENES);
    end else begin
      len_c = CW'(len_raw);
    end
    len32 = 32'(len_c);
    lenm1 = len32 - 32'd1;
    ca32  = (32'(req_i.cut_first) > lenm1) ? lenm1 : 32'(req_i.cut_first);
    cb32  = (32'(req_i.cut_second) > lenm1) ? lenm1 : 32'(req_i.cut_second);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      len_q     <= len_c;
      lo_q      <= IW'((ca32 < cb32) ? ca32 : cb32);
      hi_q      <= IW'((ca32 < cb32) ? cb32 : ca32);
      pos_q     <= IW'(32'(req_i.position));
      posb_q    <= IW'(32'(req_i.cut_first));
      pos_ok_q  <= 32'(req_i.position) < 32'(MAX_GENES);
      swap_ok_q <= (32'(req_i.position) < 32'(MAX_GENES)) &&
                   (32'(req_i.cut_first) < 32'(MAX_GENES));
      tok_a_q   <= TW'(32'(req_i.first_token));
      tok_b_q   <= TW'(32'(req_i.second_token));
    end
  end

  // memories
  logic [TW-1:0] fp_mem [MAX_GENES];
  logic [TW-1:0] sp_mem [MAX_GENES];
  logic [TW:0]   ch_mem [MAX_GENES];
  logic [TW-1:0] fp_rd_q, sp_rd_q;
  logic [TW:0]   ch_rd_q;

  logic          fp_we, fp_re, sp_re, ch_we;
  logic [IW-1:0] fp_wa, fp_ra, sp_ra, ch_wa;
  logic [TW-1:0] fp_wd;
  logic [TW:0]   ch_wd;

  // sequencing registers
  logic [IW-1:0] k_q, ptr_q, fill_pos_q;
  logic [CW-1:0] fa_q, fb_q, budget_q, used_cnt_q, tries_q, fill_left_q;
  logic          cnt_v_q, hit_q, ev_q, elast_q;
  logic [IW-1:0] epos_q;
  logic [TW-1:0] tok_q;
  logic [TW-1:0] used_q [MAX_GENES];

  logic [TW-1:0] cmp_tok;
  logic          hit_d;
  logic [31:0]   blk_len;
  logic [IW-1:0] scan_start, ptr_nx, fill_nx;
  logic          zero_take, take, fail, fill_done, ins_ok;

  assign blk_len    = 32'(hi_q) - 32'(lo_q) + 32'd1;
  assign scan_start = (32'(hi_q) + 32'd1 == 32'(len_q)) ? '0 : IW'(32'(hi_q) + 32'd1);
  assign ptr_nx     = (32'(ptr_q) + 32'd1 == 32'(len_q)) ? '0 : IW'(32'(ptr_q) + 32'd1);
  assign fill_nx    = (32'(fill_pos_q) + 32'd1 == 32'(len_q)) ? '0 :
                      IW'(32'(fill_pos_q) + 32'd1);

  // free tokens bypass the used set while budget lasts
  assign zero_take = (tok_q == '0) && (budget_q != '0);
  assign take      = zero_take || !hit_q;
  assign fail      = !take && (32'(tries_q) + 32'd1 == 32'(len_q));
  assign fill_done = ctrl_i.scan_dec && (take || fail);
  assign ins_ok    = 32'(used_cnt_q) < 32'(MAX_GENES);

  // read and write port selection
  always_comb begin
    fp_we = 1'b0;
    fp_wa = pos_q;
    fp_wd = tok_a_q;
    if (ctrl_i.load_wr && pos_ok_q) begin
      fp_we = 1'b1;
    end else if (ctrl_i.swap_wr_a && swap_ok_q) begin
      fp_we = 1'b1;
      fp_wd = fp_rd_q;
    end else if (ctrl_i.swap_wr_b && swap_ok_q) begin
      fp_we = 1'b1;
      fp_wa = posb_q;
      fp_wd = tok_q;
    end
    fp_re = ctrl_i.swap_rd_a || ctrl_i.swap_rd_b || ctrl_i.cnt_rd || ctrl_i.mark_rd;
    fp_ra = ctrl_i.swap_rd_a ? pos_q : (ctrl_i.swap_rd_b ? posb_q : k_q);
    sp_re = ctrl_i.cnt_rd || ctrl_i.scan_rd;
    sp_ra = ctrl_i.scan_rd ? ptr_q : k_q;
    ch_we = ctrl_i.mark_chk || fill_done;
    ch_wa = ctrl_i.mark_chk ? k_q : fill_pos_q;
    if (ctrl_i.mark_chk) begin
      ch_wd = {1'b0, fp_rd_q};
    end else if (fail) begin
      ch_wd = {1'b1, {TW{1'b0}}};
    end else begin
      ch_wd = {1'b0, tok_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (fp_we) fp_mem[fp_wa] <= fp_wd;
    if (fp_re) fp_rd_q <= fp_mem[fp_ra];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_wr && pos_ok_q) sp_mem[pos_q] <= tok_b_q;
    if (sp_re) sp_rd_q <= sp_mem[sp_ra];
  end

  always_ff @(posedge clk_i) begin
    if (ch_we) ch_mem[ch_wa] <= ch_wd;
    if (ctrl_i.emit_rd) ch_rd_q <= ch_mem[k_q];
  end

  // used-set lookup, one compare per lane
  assign cmp_tok = ctrl_i.mark_chk ? fp_rd_q : sp_rd_q;

  always_comb begin
    hit_d = 1'b0;
    for (int j = 0; j < MAX_GENES; j++) begin
      if ((CW'(j) < used_cnt_q) && (used_q[j] == cmp_tok)) hit_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.swap_rd_b) tok_q <= fp_rd_q;
    if (ctrl_i.mark_chk || ctrl_i.scan_chk) begin
      tok_q <= cmp_tok;
      hit_q <= hit_d;
    end
    if (((ctrl_i.mark_upd && !hit_q) || (fill_done && take && !zero_take)) && ins_ok) begin
      used_q[used_cnt_q[IW-1:0]] <= tok_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      ptr_q       <= '0;
      fill_pos_q  <= '0;
      fa_q        <= '0;
      fb_q        <= '0;
      budget_q    <= '0;
      used_cnt_q  <= '0;
      tries_q     <= '0;
      fill_left_q <= '0;
      cnt_v_q     <= 1'b0;
      ev_q        <= 1'b0;
      elast_q     <= 1'b0;
      epos_q      <= '0;
    end else begin
      cnt_v_q <= ctrl_i.cnt_rd;
      ev_q    <= ctrl_i.emit_rd;
      if (ctrl_i.capture) begin
        k_q  <= '0;
        fa_q <= '0;
        fb_q <= '0;
      end
      if (ctrl_i.cnt_rd) k_q <= k_q + IW'(1);
      // zero counts follow the registered read in the next cycle
      if (cnt_v_q) begin
        if (fp_rd_q == '0) fa_q <= fa_q + CW'(1);
        if (sp_rd_q == '0) fb_q <= fb_q + CW'(1);
      end
      if (ctrl_i.budget_set) begin
        budget_q   <= (fa_q > fb_q) ? fa_q : fb_q;
        used_cnt_q <= '0;
        k_q        <= lo_q;
      end
      if (ctrl_i.mark_upd) begin
        k_q <= k_q + IW'(1);
        if (!hit_q && ins_ok) used_cnt_q <= used_cnt_q + CW'(1);
      end
      if (ctrl_i.scan_init) begin
        ptr_q       <= scan_start;
        fill_pos_q  <= scan_start;
        fill_left_q <= CW'(32'(len_q) - blk_len);
        tries_q     <= '0;
        k_q         <= '0;
      end
      if (ctrl_i.scan_rd) ptr_q <= ptr_nx;
      if (ctrl_i.scan_dec) begin
        if (fill_done) begin
          tries_q     <= '0;
          fill_left_q <= fill_left_q - CW'(1);
          fill_pos_q  <= fill_nx;
          if (zero_take) begin
            budget_q <= budget_q - CW'(1);
          end else if (take && ins_ok) begin
            used_cnt_q <= used_cnt_q + CW'(1);
          end
        end else begin
          tries_q <= tries_q + CW'(1);
        end
      end
      if (ctrl_i.emit_rd) begin
        k_q     <= k_q + IW'(1);
        epos_q  <= k_q;
        elast_q <= 32'(k_q) + 32'd1 == 32'(len_q);
      end
    end
  end

  assign stat_o.cnt_last  = 32'(k_q) + 32'd1 == 32'(len_q);
  assign stat_o.mark_last = k_q == hi_q;
  assign stat_o.fill_none = blk_len == 32'(len_q);
  assign stat_o.fill_done = fill_done;
  assign stat_o.fill_last = fill_left_q == CW'(1);
  assign stat_o.emit_last = 32'(k_q) + 32'd1 == 32'(len_q);

  assign result_valid_o       = ev_q;
  assign rsp_o.child_position = POS_W'(32'(epos_q));
  assign rsp_o.child_token    = TOK_W'(32'(ch_rd_q[TW-1:0]));
  assign rsp_o.last           = elast_q;
  assign rsp_o.error          = ch_rd_q[TW];

endmodule

[rtl/core/order_crossover_engine_unit.sv]
// top level of the order crossover engine
//
// channel   direction  handshake                       payload
// request   in         start && !busy                  req_i   (req_t)
// result    out        result_valid_o, one cycle each  rsp_o   (rsp_t)
// config    in         psel && penable && pwrite       pwdata  (length_in_use at 0x0)
//
// a load writes both parents at once; a swap steps through read, read, write, write
// a run walks the count, mark, scan and emit phases; the scan loops through a
// second-parent read, a used-set compare and a decide step for each try of the
// circular scan, and results come out in the emit phase
// results leave one per cycle, position 0 first, and cannot be stalled
// reset clears the sequencer and counters; parent storage is undefined until loaded
`timescale 1ns / 1ps
`include "order_crossover_engine_unit_assert.svh"
module order_crossover_engine_unit import ocx_pkg::*; #(
  parameter int MAX_GENES  = 32,
  parameter int TOKEN_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  req_t        req_i,
  output logic        result_valid_o,
  output rsp_t        rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // length register, one word at byte address zero
  logic [LEN_W-1:0] len_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_cfg_q <= LEN_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      len_cfg_q <= pwdata[LEN_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : 32'(len_cfg_q);

  ctrl_t ctrl;
  stat_t stat;

  // sequencer: walks load, swap and the count, mark, scan and emit phases of a run
  ocx_controller u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .cmd_i  (req_i.command),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .busy_o (busy)
  );

  // storage, used-set lanes and result register
  ocx_datapath #(
    .MAX_GENES (MAX_GENES),
    .TOKEN_BITS(TOKEN_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_i),
    .len_cfg_i     (len_cfg_q),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .result_valid_o(result_valid_o),
    .rsp_o         (rsp_o)
  );

  // results only appear while a run is in progress
  `OCX_ASSERT_NOW(a_result_busy, clk_i, rst_ni, result_valid_o, busy)
  // a known request keeps the block busy the cycle after
  `OCX_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni,
    start && !busy && (req_i.command == CMD_LOAD || req_i.command == CMD_SWAP ||
    req_i.command == CMD_RUN), busy)
  // nothing follows the last result of a run
  `OCX_ASSERT_NEXT(a_last_ends, clk_i, rst_ni, result_valid_o && rsp_o.last,
    !result_valid_o)

endmodule

[test/order_crossover_engine_unit_tb.sv]
// self-checking testbench for the order crossover engine: directed table plus random traffic
`timescale 1ns / 1ps
module order_crossover_engine_unit_tb;
  import ocx_pkg::*;

  localparam int GENES = 32;
  localparam logic [1:0] CMD_NONE = 2'd3;   // unknown command, ignored by the block
  localparam logic [2:0] REG_LENGTH = 3'd0; // length_in_use lies at byte address 0
  localparam int SETTLE_CYCLES = 40;        // covers a swap and the run wrap-up

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  req_t        req_i = '0;
  logic        result_valid_o;
  rsp_t        rsp_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  order_crossover_engine_unit u_dut (
    .clk_i, .rst_ni, .start, .busy, .req_i, .result_valid_o, .rsp_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // hard stop in case the block hangs
  initial begin
    #15ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------
  // predictor state: own copy of the parents and of the scan bookkeeping
  // ---------------------------------------------------------------
  logic [TOK_W-1:0] mom_genes [GENES];
  logic [TOK_W-1:0] dad_genes [GENES];
  logic [TOK_W-1:0] taken_tokens [GENES];
  int unsigned      taken_count;
  int unsigned      zero_allowance;
  int unsigned      dad_cursor;
  logic [LEN_W-1:0] genes_in_use = LEN_RESET;

  rsp_t child_q[$];   // expected child genes, oldest first
  int   mismatch_count = 0;

  task automatic report_mismatch(input string what, input rsp_t got, input rsp_t want);
    $display("mismatch %s: got pos %0d tok %h last %b err %b, want pos %0d tok %h last %b err %b",
             what, got.child_position, got.child_token, got.last, got.error,
             want.child_position, want.child_token, want.last, want.error);
    mismatch_count++;
  endtask

  task automatic report_value(input string what, input logic [31:0] got,
                              input logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    mismatch_count++;
  endtask

  function automatic bit is_taken(input logic [TOK_W-1:0] tok);
    for (int i = 0; i < taken_count && i < GENES; i++)
      if (taken_tokens[i] == tok) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void take_token(input logic [TOK_W-1:0] tok);
    if (!is_taken(tok) && taken_count < GENES) begin
      taken_tokens[taken_count] = tok;
      taken_count++;
    end
  endfunction

  // next eligible second-parent gene, circular; 0 means a full circle found nothing
  function automatic bit next_dad_gene(input int unsigned len, output logic [TOK_W-1:0] tok);
    logic [TOK_W-1:0] cand;
    for (int tries = 0; tries < len; tries++) begin
      cand = dad_genes[dad_cursor % len];
      dad_cursor = (dad_cursor + 1) % len;
      if (cand == '0 && zero_allowance > 0) begin
        zero_allowance--;
        tok = cand;
        return 1'b1;
      end
      if (!is_taken(cand)) begin
        take_token(cand);
        tok = cand;
        return 1'b1;
      end
    end
    tok = '0;
    return 1'b0;
  endfunction

  function automatic void predict_request(input req_t r);
    int unsigned len, lo, hi, ca, cb, mom_free, dad_free;
    logic [TOK_W-1:0] child [GENES];
    bit               fail [GENES];
    logic [TOK_W-1:0] t;
    rsp_t             e;
    case (r.command)
      CMD_LOAD: begin
        mom_genes[r.position] = r.first_token;
        dad_genes[r.position] = r.second_token;
      end
      CMD_SWAP: begin
        t = mom_genes[r.position];
        mom_genes[r.position] = mom_genes[r.cut_first];
        mom_genes[r.cut_first] = t;
      end
      CMD_RUN: begin
        len = genes_in_use;
        if (len < 2) len = 2;
        if (len > GENES) len = GENES;
        ca = (r.cut_first > len - 1) ? len - 1 : r.cut_first;
        cb = (r.cut_second > len - 1) ? len - 1 : r.cut_second;
        lo = (ca < cb) ? ca : cb;
        hi = (ca < cb) ? cb : ca;
        mom_free = 0;
        dad_free = 0;
        for (int i = 0; i < len; i++) begin
          if (mom_genes[i] == '0) mom_free++;
          if (dad_genes[i] == '0) dad_free++;
        end
        zero_allowance = (mom_free > dad_free) ? mom_free : dad_free;
        taken_count = 0;
        for (int i = 0; i < len; i++) begin
          child[i] = mom_genes[i];
          fail[i] = 1'b0;
        end
        // center block is copied from the first parent and marks its tokens as used
        for (int i = lo; i <= hi; i++) take_token(mom_genes[i]);
        dad_cursor = (hi + 1) % len;
        for (int i = hi + 1; i < len; i++) fail[i] = !next_dad_gene(len, child[i]);
        for (int i = 0; i < lo; i++) fail[i] = !next_dad_gene(len, child[i]);
        for (int i = 0; i < len; i++) begin
          e.child_position = POS_W'(i);
          e.child_token = child[i];
          e.last = (i == len - 1);
          e.error = fail[i];
          child_q = {child_q, e};
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------
  // result checker: every strobe is matched against the oldest expectation
  // ---------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (child_q.size() == 0) begin
        report_mismatch("unexpected result", rsp_o, '0);
      end else begin
        if (rsp_o !== child_q[0]) report_mismatch("child gene", rsp_o, child_q[0]);
        void'(child_q.pop_front());
      end
    end
  end

  // ---------------------------------------------------------------
  // request driver: bursts of back-to-back requests with random gaps
  // ---------------------------------------------------------------
  int burst_left = 0;

  task automatic send_request(input req_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    req_i <= r;
    start <= 1'b1;
    // accepted at the first edge with busy low
    do @(posedge clk_i); while (busy);
    predict_request(r);
  endtask

  // drain all results, then let the block settle back to idle
  task automatic wait_idle();
    start <= 1'b0;
    burst_left = 0;
    while (child_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // apb write of length_in_use followed by a read-back
  task automatic set_length(input logic [31:0] value);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= REG_LENGTH; pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    genes_in_use = value[LEN_W-1:0];
    @(posedge clk_i);
    psel <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== {26'b0, genes_in_use})
      report_value("length readback", prdata, {26'b0, genes_in_use});
    psel <= 1'b0; penable <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic req_t make_req(input logic [1:0] cmd, input int pos,
                                    input int ta, input int tb, input int ca, input int cb);
    req_t r;
    r.command = cmd;
    r.position = POS_W'(pos);
    r.first_token = TOK_W'(ta);
    r.second_token = TOK_W'(tb);
    r.cut_first = POS_W'(ca);
    r.cut_second = POS_W'(cb);
    return r;
  endfunction

  // small pool so that repeats, free slots and failed scans all happen
  function automatic logic [TOK_W-1:0] pick_token();
    int k;
    k = $urandom_range(0, 9);
    if (k < 3) return '0;
    if (k < 8) return TOK_W'($urandom_range(1, 6));
    if (k == 8) return 16'hFFFF;
    return TOK_W'($urandom);
  endfunction

  function automatic req_t random_request();
    int k;
    k = $urandom_range(0, 99);
    if (k < 45) return make_req(CMD_LOAD, $urandom_range(0, 31), pick_token(), pick_token(),
                                $urandom_range(0, 31), $urandom_range(0, 31));
    if (k < 60) return make_req(CMD_SWAP, $urandom_range(0, 31), $urandom, $urandom,
                                $urandom_range(0, 31), $urandom_range(0, 31));
    if (k < 88) return make_req(CMD_RUN, $urandom_range(0, 31), $urandom, $urandom,
                                $urandom_range(0, 31), $urandom_range(0, 31));
    // noise: unknown command with random content
    return make_req(CMD_NONE, $urandom_range(0, 31), $urandom, $urandom,
                    $urandom_range(0, 31), $urandom_range(0, 31));
  endfunction

  // directed table; first_child is typed only for rows with an obvious answer
  typedef struct {
    req_t req;
    bit   typed;
    rsp_t first_child;
  } stim_row_t;

  stim_row_t dir_rows[$];

  function automatic void add_row(input req_t r, input bit typed = 1'b0,
                                  input rsp_t first = '0);
    stim_row_t row;
    row.req = r;
    row.typed = typed;
    row.first_child = first;
    dir_rows = {dir_rows, row};
  endfunction

  int phase_len[5];

  initial begin
    int idx;
    for (int i = 0; i < GENES; i++) begin
      mom_genes[i] = '0;
      dad_genes[i] = '0;
      taken_tokens[i] = '0;
    end
    taken_count = 0;
    zero_allowance = 0;
    dad_cursor = 0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part runs with four genes
    set_length(32'd4);
    add_row(make_req(CMD_LOAD, 0, 16'hFFFF, 0, 0, 0));
    add_row(make_req(CMD_LOAD, 1, 0, 16'hFFFF, 0, 0));
    add_row(make_req(CMD_LOAD, 2, 5, 5, 0, 0));
    add_row(make_req(CMD_LOAD, 3, 7, 9, 0, 0));
    // position past the length is stored like any other
    add_row(make_req(CMD_LOAD, 31, 16'h1234, 16'hABCD, 31, 31));
    add_row(make_req(CMD_SWAP, 0, 0, 0, 3, 0));
    // cuts spanning the whole length copy the first parent: 7, 0, 5, ffff
    add_row(make_req(CMD_RUN, 0, 0, 0, 0, 3), 1'b1, '{5'd0, 16'd7, 1'b0, 1'b0});
    add_row(make_req(CMD_RUN, 0, 0, 0, 3, 1));     // cuts given in reverse order
    add_row(make_req(CMD_RUN, 31, 0, 0, 31, 31));  // cuts saturate to length - 1
    add_row(make_req(CMD_NONE, 31, 16'hFFFF, 16'hFFFF, 31, 31));
    add_row(make_req(CMD_SWAP, 3, 0, 0, 3, 0));    // swap with itself
    // second parent offers one distinct token only: scan runs dry
    add_row(make_req(CMD_LOAD, 0, 1, 1, 0, 0));
    add_row(make_req(CMD_LOAD, 1, 2, 1, 0, 0));
    add_row(make_req(CMD_LOAD, 2, 3, 1, 0, 0));
    add_row(make_req(CMD_LOAD, 3, 4, 1, 0, 0));
    add_row(make_req(CMD_RUN, 0, 0, 0, 1, 1));
    add_row(make_req(CMD_RUN, 0, 0, 0, 0, 0));
    add_row(make_req(CMD_LOAD, 31, 16'hFFFF, 16'hFFFF, 31, 31));

    foreach (dir_rows[i]) begin
      idx = child_q.size();
      send_request(dir_rows[i].req);
      if (dir_rows[i].typed && child_q[idx] !== dir_rows[i].first_child)
        report_mismatch("typed first child", child_q[idx], dir_rows[i].first_child);
    end
    wait_idle();

    // fill every position so that any length reads only loaded genes
    for (int p = 0; p < GENES; p++)
      send_request(make_req(CMD_LOAD, p, pick_token(), pick_token(), 0, 0));
    wait_idle();

    // length settings: extremes, clamped values below and above, then a random one
    phase_len[0] = 2;
    phase_len[1] = 32;
    phase_len[2] = 0;
    phase_len[3] = 63;
    phase_len[4] = $urandom_range(3, 31);
    foreach (phase_len[ph]) begin
      set_length(phase_len[ph]);
      for (int n = 0; n < 32; n++) send_request(random_request());
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
